@@ src/psrl_pkg.sv @@
// shared types, constants and functions for the per-source rate limiter
package psrl_pkg;

  localparam int unsigned TABLE_DEPTH_DEFAULT = 1024;

  localparam logic [1:0] KIND_CONNECT = 2'd0;
  localparam logic [1:0] KIND_CLOSE   = 2'd1;
  localparam logic [1:0] KIND_SWEEP   = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  localparam logic [1:0] VERDICT_OK       = 2'd0;
  localparam logic [1:0] VERDICT_BANNED   = 2'd1;
  localparam logic [1:0] VERDICT_OPEN     = 2'd2;
  localparam logic [1:0] VERDICT_RATE     = 2'd3;

  localparam logic [2:0] REG_WINDOW  = 3'd0;
  localparam logic [2:0] REG_MAX_REQ = 3'd1;
  localparam logic [2:0] REG_MAX_OPEN = 3'd2;
  localparam logic [2:0] REG_VIOL    = 3'd3;
  localparam logic [2:0] REG_BAN     = 3'd4;
  localparam logic [2:0] REG_BYPASS  = 3'd5;

  localparam logic [31:0] HASH_SEED = 32'd5381;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] source_addr;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic        allowed;
    logic [1:0]  verdict;
    logic        ban_started;
    logic [10:0] cleared_count;
  } rsp_t;

  typedef struct packed {
    logic [15:0] window_seconds;
    logic [15:0] max_requests;
    logic [15:0] max_open;
    logic [7:0]  violations_to_ban;
    logic [19:0] ban_seconds;
    logic        bypass_mode;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [31:0] win_begin;
    logic [15:0] requests;
    logic [31:0] last_seen;
    logic [15:0] open;
    logic [7:0]  violations;
    logic [31:0] ban_end;
  } rec_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request
    logic hash;      // one hash byte step
    logic rd;        // issue read at index
    logic eval;      // compute and write back connect/close
    logic clr_start; // start clear or sweep counter
    logic sweep_rd;  // read at sweep counter
    logic sweep_wr;  // evaluate and advance sweep
    logic clr_wr;    // clear at sweep counter
  } cmd_t;

  typedef struct packed {
    logic last; // counter at last entry
  } sts_t;

  function automatic logic [31:0] hash_step(logic [31:0] h, logic [7:0] b);
    return (h << 5) + h + {24'd0, b};
  endfunction

  function automatic logic [15:0] sat_inc16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

@@ src/psrl_if.sv @@
// valid/ready channel interfaces
interface psrl_req_if;
  logic           valid;
  logic           ready;
  psrl_pkg::req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface psrl_rsp_if;
  logic           valid;
  logic           ready;
  psrl_pkg::rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface psrl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] wdata;
  modport source(output valid, output index, output wdata, input ready);
  modport sink(input valid, input index, input wdata, output ready);
endinterface

@@ src/psrl_ctrl.sv @@
// sequencing state machine of the rate limiter
module psrl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic [1:0]     kind,
  input  psrl_pkg::sts_t sts,
  output psrl_pkg::cmd_t cmd
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_READ  = 4'd3;
  localparam logic [3:0] S_WAIT  = 4'd4;
  localparam logic [3:0] S_EVAL  = 4'd5;
  localparam logic [3:0] S_SW_RD = 4'd6;
  localparam logic [3:0] S_SW_EV = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state, state_next;
  logic [1:0] step, step_next;

  assign in_ready  = (state == S_IDLE) && !out_valid;

  logic out_set;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      if (out_set) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    step_next = step;
    cmd = '0;
    out_set = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          cmd.clr_start = 1'b1;
          step_next = '0;
          if (kind == psrl_pkg::KIND_SWEEP) state_next = S_SW_RD;
          else if (kind == psrl_pkg::KIND_CONNECT || kind == psrl_pkg::KIND_CLOSE)
            state_next = S_HASH;
          else state_next = S_DONE;
        end
      end
      S_HASH: begin
        cmd.hash = 1'b1;
        step_next = step + 2'd1;
        if (step == 2'd3) state_next = S_READ;
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: state_next = S_EVAL;
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_next = S_DONE;
      end
      S_SW_RD: begin
        cmd.sweep_rd = 1'b1;
        state_next = S_SW_EV;
      end
      S_SW_EV: begin
        cmd.sweep_wr = 1'b1;
        state_next = sts.last ? S_DONE : S_SW_RD;
      end
      S_DONE: begin
        out_set = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

@@ src/psrl_dp.sv @@
// record table, hash and verdict datapath
module psrl_dp #(
  parameter int unsigned TABLE_DEPTH = psrl_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  psrl_pkg::cmd_t cmd,
  output psrl_pkg::sts_t sts,
  input  psrl_pkg::req_t req,
  input  psrl_pkg::cfg_t cfg,
  output psrl_pkg::rsp_t rsp
);
  localparam int IW = $clog2(TABLE_DEPTH);

  psrl_pkg::rec_t mem [TABLE_DEPTH];
  psrl_pkg::rec_t rd_rec;
  psrl_pkg::req_t req_q;
  logic [31:0] h;
  logic [1:0]  byte_sel;
  logic [IW-1:0] cnt;
  logic [IW-1:0] idx;
  logic [11:0] n_clr;

  logic        we;
  logic [IW-1:0] waddr;
  psrl_pkg::rec_t wrec;

  assign sts.last = (cnt == IW'(TABLE_DEPTH - 1));
  assign idx = h[IW-1:0];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wrec;
    if (cmd.rd) rd_rec <= mem[idx];
    else if (cmd.sweep_rd) rd_rec <= mem[cnt];
  end

  // signed ages
  logic signed [33:0] age_ws, age_ls, w2, w4, w1;
  always_comb begin
    age_ws = $signed({2'b00, req_q.now_seconds}) - $signed({2'b00, rd_rec.win_begin});
    age_ls = $signed({2'b00, req_q.now_seconds}) - $signed({2'b00, rd_rec.last_seen});
    w1 = $signed({18'd0, cfg.window_seconds});
    w2 = $signed({17'd0, cfg.window_seconds, 1'b0});
    w4 = $signed({16'd0, cfg.window_seconds, 2'b00});
  end

  logic [32:0] until_sum;
  assign until_sum = {1'b0, req_q.now_seconds} + {13'd0, cfg.ban_seconds};

  psrl_pkg::rec_t r, nr;
  logic        c_allow, c_ban;
  logic [1:0]  c_verdict;
  logic [15:0] nreq;
  logic [7:0]  nviol;
  always_comb begin
    r = rd_rec;
    nr = rd_rec;
    c_allow = 1'b0;
    c_ban = 1'b0;
    c_verdict = psrl_pkg::VERDICT_OK;
    nreq = psrl_pkg::sat_inc16(rd_rec.requests);
    nviol = '0;
    if (req_q.kind == psrl_pkg::KIND_CLOSE) begin
      if (r.valid && r.addr == req_q.source_addr && r.open != 16'd0)
        nr.open = r.open - 16'd1;
    end else if (r.ban_end != 32'd0 && req_q.now_seconds < r.ban_end) begin
      c_verdict = psrl_pkg::VERDICT_BANNED;
    end else begin
      if (r.ban_end != 32'd0) begin
        r.ban_end = '0;
        r.violations = '0;
      end
      nr = r;
      nviol = (r.violations == 8'hFF) ? r.violations : r.violations + 8'd1;
      if (!r.valid || r.addr != req_q.source_addr || age_ws > w2) begin
        nr.valid = 1'b1;
        nr.addr = req_q.source_addr;
        nr.win_begin = req_q.now_seconds;
        nr.requests = 16'd1;
        nr.last_seen = req_q.now_seconds;
        nr.open = 16'd1;
        c_allow = 1'b1;
      end else if (r.open >= cfg.max_open) begin
        c_verdict = psrl_pkg::VERDICT_OPEN;
      end else if (age_ws >= w1) begin
        nr.win_begin = req_q.now_seconds;
        nr.requests = 16'd1;
        nr.last_seen = req_q.now_seconds;
        nr.open = psrl_pkg::sat_inc16(r.open);
        c_allow = 1'b1;
      end else begin
        nr.requests = nreq;
        nr.last_seen = req_q.now_seconds;
        nr.open = psrl_pkg::sat_inc16(r.open);
        if (nreq > cfg.max_requests) begin
          nr.violations = nviol;
          if (nviol >= cfg.violations_to_ban) begin
            nr.ban_end = until_sum[32] ? 32'hFFFF_FFFF : until_sum[31:0];
            c_ban = 1'b1;
          end
          c_verdict = psrl_pkg::VERDICT_RATE;
        end else begin
          c_allow = 1'b1;
        end
      end
    end
  end

  logic sw_hit;
  assign sw_hit = rd_rec.valid && rd_rec.ban_end == 32'd0 && age_ls > w4;

  always_comb begin
    we = 1'b0;
    waddr = idx;
    wrec = nr;
    if (cmd.clr_wr) begin
      we = 1'b1;
      waddr = cnt;
      wrec = '0;
    end else if (cmd.sweep_wr) begin
      we = sw_hit;
      waddr = cnt;
      wrec = '0;
    end else if (cmd.eval) begin
      we = 1'b1;
    end
  end

  // bypassed connects are answered from the request alone
  psrl_pkg::rsp_t rsp_init;
  always_comb begin
    rsp_init = '0;
    rsp_init.allowed = req.kind == psrl_pkg::KIND_CONNECT && cfg.bypass_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      n_clr <= '0;
      rsp <= '0;
    end else begin
      if (cmd.clr_start) begin
        cnt <= '0;
        n_clr <= '0;
        rsp <= rsp_init;
      end else if (cmd.clr_wr || cmd.sweep_wr) begin
        cnt <= cnt + IW'(1);
      end
      if (cmd.sweep_wr) begin
        if (sw_hit) n_clr <= n_clr + 12'd1;
        if (sts.last) rsp.cleared_count <= (sw_hit ? n_clr + 12'd1 : n_clr) > 12'd2047
          ? 11'd2047 : 11'(sw_hit ? n_clr + 12'd1 : n_clr);
      end
      if (cmd.eval && req_q.kind == psrl_pkg::KIND_CONNECT) begin
        rsp.allowed <= c_allow;
        rsp.verdict <= c_verdict;
        rsp.ban_started <= c_ban;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
      h <= psrl_pkg::HASH_SEED;
      byte_sel <= '0;
    end else if (cmd.hash) begin
      h <= psrl_pkg::hash_step(h, req_q.source_addr[8*(3-byte_sel) +: 8]);
      byte_sel <= byte_sel + 2'd1;
    end
  end
endmodule

@@ src/per_source_rate_limiter_top.sv @@
// top level of the per-source rate limiter
//  channel | dir | payload
//  req     | in  | kind, source_addr, now_seconds
//  rsp     | out | allowed, verdict, ban_started, cleared_count
//  cfg     | in  | index, wdata
// connect and close: the response is made valid after these steps, once the request is taken
//   (4 hash steps, table read, read wait, evaluate and write back, response register)
// a sweep reads and then evaluates each table entry in turn; response valid after the last entry
// kind 3 and bypassed connects: done state and response register only, no table access
// after reset a clearing pass over every table entry runs before requests are taken
// one request at a time; the next is taken the cycle after the response is delivered
module per_source_rate_limiter_top #(
  parameter int unsigned TABLE_DEPTH = psrl_pkg::TABLE_DEPTH_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  psrl_req_if.sink   req,
  psrl_rsp_if.source rsp,
  psrl_cfg_if.sink   cfg
);
  psrl_pkg::cfg_t cfg_q;
  psrl_pkg::cmd_t cmd;
  psrl_pkg::sts_t sts;
  psrl_pkg::rsp_t rsp_d;
  logic bypass_hit;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.window_seconds <= 16'd60;
      cfg_q.max_requests <= 16'd100;
      cfg_q.max_open <= 16'd10;
      cfg_q.violations_to_ban <= 8'd3;
      cfg_q.ban_seconds <= 20'd300;
      cfg_q.bypass_mode <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        psrl_pkg::REG_WINDOW:   cfg_q.window_seconds <= cfg.wdata[15:0];
        psrl_pkg::REG_MAX_REQ:  cfg_q.max_requests <= cfg.wdata[15:0];
        psrl_pkg::REG_MAX_OPEN: cfg_q.max_open <= cfg.wdata[15:0];
        psrl_pkg::REG_VIOL:     cfg_q.violations_to_ban <= cfg.wdata[7:0];
        psrl_pkg::REG_BAN:      cfg_q.ban_seconds <= cfg.wdata[19:0];
        psrl_pkg::REG_BYPASS:   cfg_q.bypass_mode <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  // bypassed connects skip the table entirely
  logic [1:0] ctrl_kind;
  assign bypass_hit = cfg_q.bypass_mode && req.data.kind == psrl_pkg::KIND_CONNECT;
  assign ctrl_kind = bypass_hit ? psrl_pkg::KIND_UNUSED : req.data.kind;

  psrl_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .kind(ctrl_kind), .sts, .cmd
  );

  psrl_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk, .rst, .cmd, .sts, .req(req.data), .cfg(cfg_q), .rsp(rsp_d)
  );

  assign rsp.data = rsp_d;

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("request taken with response pending");
  a_verdict_allow: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.allowed |-> rsp.data.verdict == psrl_pkg::VERDICT_OK)
    else $error("allowed with refusal verdict");
  a_ban_rate: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.ban_started |-> rsp.data.verdict == psrl_pkg::VERDICT_RATE)
    else $error("ban without rate verdict");
endmodule
